// ===== hw/rtl/scai_pkg.sv =====
// shared types and constants for the swept box collision interval unit
// no dependencies
package scai_pkg;

	localparam int NUM_AXES = 3;
	localparam int AREA_LAT = 4;

	typedef logic [1:0] axis_t;

	localparam axis_t AXIS_X    = 2'd0;
	localparam axis_t AXIS_Y    = 2'd1;
	localparam axis_t AXIS_Z    = 2'd2;
	localparam axis_t AXIS_NONE = 2'd3;

	// one input word plus per-axis flags worked out at the front
	typedef struct packed {
		logic [2:0][30:0] size;
		logic [2:0][31:0] lo;
		logic [2:0][31:0] hi;
		logic [2:0][31:0] mv;
		logic [2:0]       qneg1;
		logic [2:0]       qneg2;
		logic [2:0]       still_ok;
	} item_t;

	typedef struct packed {
		logic        hit;
		logic        still;
		logic [31:0] t_enter;
		logic [31:0] t_exit;
		axis_t       enter_axis;
		logic        enter_neg;
		axis_t       exit_axis;
		logic        exit_neg;
	} res_t;

endpackage

// ===== hw/rtl/scai_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
// no dependencies
module scai_div #(
	parameter int NB = 48,
	parameter int DB = 32
) (
	input  logic          clk,
	input  logic [NB-1:0] dividend,
	input  logic [DB-1:0] divisor,
	output logic [NB-1:0] quotient
);

	logic [DB-1:0] rem_s [NB];
	logic [NB-1:0] dvd_s [NB];
	logic [NB-1:0] quo_s [NB];
	logic [DB-1:0] dvs_s [NB];

	genvar i;
	for (i = 0; i < NB; i++) begin : g_stage
		logic [DB-1:0] rem_in;
		logic [DB-1:0] dvs_in;
		logic [NB-1:0] dvd_in;
		logic [NB-1:0] quo_in;
		logic [DB:0]   trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign dvs_in = divisor;
			assign dvd_in = dividend;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign dvs_in = dvs_s[i-1];
			assign dvd_in = dvd_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {rem_in, dvd_in[NB-1]};
		assign ge    = trial >= {1'b0, dvs_in};

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? DB'(trial - {1'b0, dvs_in}) : trial[DB-1:0];
			dvd_s[i] <= {dvd_in[NB-2:0], 1'b0};
			quo_s[i] <= {quo_in[NB-2:0], ge};
			dvs_s[i] <= dvs_in;
		end
	end

	assign quotient = quo_s[NB-1];

endmodule

// ===== hw/rtl/scai_delay.sv =====
// delay line carrying a valid bit and a side word alongside the datapath
// no dependencies
module scai_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	output logic [W-1:0] out_data
);

	logic         valid_q [DEPTH];
	logic [W-1:0] data_q  [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) valid_q[i] <= 1'b0;
		end else begin
			valid_q[0] <= in_valid;
			for (int i = 1; i < DEPTH; i++) valid_q[i] <= valid_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		data_q[0] <= in_data;
		for (int i = 1; i < DEPTH; i++) data_q[i] <= data_q[i-1];
	end

	assign out_valid = valid_q[DEPTH-1];
	assign out_data  = data_q[DEPTH-1];

endmodule

// ===== hw/rtl/scai_area.sv =====
// contact area at one time over the two axes other than the skipped one
// depends on scai_pkg
module scai_area #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  scai_pkg::item_t     item,
	input  logic signed [31:0]  t,
	input  scai_pkg::axis_t     skip,
	output logic signed [63:0]  area
);
	import scai_pkg::*;

	localparam int DW = 64 - FRAC_BITS;
	localparam int EW = DW + 1;
	localparam int XW = EW + 1;

	logic signed [63:0]   prod_s1 [NUM_AXES];
	item_t                item_s1;
	axis_t                skip_s1;
	logic signed [DW-1:0] d_c     [NUM_AXES];
	logic signed [EW-1:0] e_c     [NUM_AXES];
	logic signed [DW-1:0] d_s2    [NUM_AXES];
	logic signed [EW-1:0] e_s2    [NUM_AXES];
	item_t                item_s2;
	axis_t                skip_s2;
	logic signed [31:0]   w_c     [NUM_AXES];
	logic signed [31:0]   w_s3    [NUM_AXES];
	axis_t                skip_s3;
	logic signed [63:0]   area_s4;

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_AXES; k++) prod_s1[k] <= $signed(item.mv[k]) * t;
		item_s1 <= item;
		skip_s1 <= skip;
	end

	// offset truncated toward zero, then far edge of the mover
	always_comb begin
		logic signed [63:0] sh;
		logic               rnd;
		for (int k = 0; k < NUM_AXES; k++) begin
			sh     = prod_s1[k] >>> FRAC_BITS;
			rnd    = prod_s1[k][63] && (prod_s1[k][FRAC_BITS-1:0] != '0);
			d_c[k] = DW'(sh) + $signed(DW'({1'b0, rnd}));
			e_c[k] = EW'(d_c[k]) + EW'($signed({1'b0, item_s1.size[k]}));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_AXES; k++) begin
			d_s2[k] <= d_c[k];
			e_s2[k] <= e_c[k];
		end
		item_s2 <= item_s1;
		skip_s2 <= skip_s1;
	end

	// overlap width, saturated but not clamped at zero
	always_comb begin
		logic signed [EW-1:0] lo_e;
		logic signed [EW-1:0] hi_e;
		logic signed [EW-1:0] a;
		logic signed [EW-1:0] b;
		logic signed [XW-1:0] diff;
		for (int k = 0; k < NUM_AXES; k++) begin
			lo_e = EW'($signed(item_s2.lo[k]));
			hi_e = EW'($signed(item_s2.hi[k]));
			a    = (EW'(d_s2[k]) > lo_e) ? EW'(d_s2[k]) : lo_e;
			b    = (e_s2[k] < hi_e) ? e_s2[k] : hi_e;
			diff = XW'(b) - XW'(a);
			if (diff[XW-1:31] == '0 || diff[XW-1:31] == '1)
				w_c[k] = diff[31:0];
			else if (diff[XW-1])
				w_c[k] = 32'sh8000_0000;
			else
				w_c[k] = 32'sh7fff_ffff;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_AXES; k++) w_s3[k] <= w_c[k];
		skip_s3 <= skip_s2;
	end

	always_ff @(posedge clk) begin
		case (skip_s3)
			AXIS_X:  area_s4 <= w_s3[1] * w_s3[2];
			AXIS_Y:  area_s4 <= w_s3[0] * w_s3[2];
			AXIS_Z:  area_s4 <= w_s3[0] * w_s3[1];
			default: area_s4 <= w_s3[0] * w_s3[1];
		endcase
	end

	assign area = area_s4;

endmodule

// ===== hw/rtl/swept_box_collision_interval_unit.sv =====
// top level of the swept box collision interval unit
// depends on scai_pkg, scai_div, scai_delay, scai_area
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | start, busy        | mover_size_*, target_min/max_*, move_*
//  out     | done (strobe)      | hit, stationary, t_enter, t_exit, axes,
//          |                    | face flags, area_enter, area_exit
//
// one word enters per cycle; busy stays low
// the path runs through the 32 + FRAC_BITS stage divider
// arst_n clears every valid bit; words in flight are dropped
// done is high for one cycle per word and the receiver cannot hold it off
module swept_box_collision_interval_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [30:0]        mover_size_x,
	input  logic [30:0]        mover_size_y,
	input  logic [30:0]        mover_size_z,
	input  logic signed [31:0] target_min_x,
	input  logic signed [31:0] target_max_x,
	input  logic signed [31:0] target_min_y,
	input  logic signed [31:0] target_max_y,
	input  logic signed [31:0] target_min_z,
	input  logic signed [31:0] target_max_z,
	input  logic signed [31:0] move_x,
	input  logic signed [31:0] move_y,
	input  logic signed [31:0] move_z,
	output logic               done,
	output logic               hit,
	output logic               stationary,
	output logic signed [31:0] t_enter,
	output logic signed [31:0] t_exit,
	output logic [1:0]         enter_axis,
	output logic               enter_moving_negative,
	output logic [1:0]         exit_axis,
	output logic               exit_moving_negative,
	output logic signed [63:0] area_enter,
	output logic signed [63:0] area_exit
);
	import scai_pkg::*;

	localparam int N   = 32 + FRAC_BITS;
	localparam int QW  = N + 1;
	localparam int LAT = 1 + N + 2 + AREA_LAT + 1;

	// front: numerators, magnitudes and signs
	item_t         item_c;
	logic [N-1:0]  dvd1_c [NUM_AXES];
	logic [N-1:0]  dvd2_c [NUM_AXES];
	logic [31:0]   dvs_c  [NUM_AXES];

	logic          valid_s1;
	item_t         item_s1;
	logic [N-1:0]  dvd1_s1 [NUM_AXES];
	logic [N-1:0]  dvd2_s1 [NUM_AXES];
	logic [31:0]   dvs_s1  [NUM_AXES];

	logic [N-1:0]  qm1 [NUM_AXES];
	logic [N-1:0]  qm2 [NUM_AXES];
	logic          valid_d;
	item_t         item_d;

	logic signed [QW-1:0] tlo_c  [NUM_AXES];
	logic signed [QW-1:0] thi_c  [NUM_AXES];
	logic [2:0]           pass_c;
	logic                 valid_s2;
	item_t                item_s2;
	logic signed [QW-1:0] tlo_s2 [NUM_AXES];
	logic signed [QW-1:0] thi_s2 [NUM_AXES];
	logic [2:0]           pass_s2;

	res_t   res_c;
	logic   valid_s3;
	item_t  item_s3;
	res_t   res_s3;

	logic signed [63:0] area_e;
	logic signed [63:0] area_x;
	logic   valid_a;
	res_t   res_a;

	logic               done_q;
	res_t               res_q;
	logic signed [63:0] area_enter_q;
	logic signed [63:0] area_exit_q;

	assign busy = 1'b0;

	always_comb begin
		logic signed [32:0] num1;
		logic               neg1;
		logic [31:0]        mag1;
		logic [31:0]        mag2;
		item_c.size = {mover_size_z, mover_size_y, mover_size_x};
		item_c.lo   = {target_min_z, target_min_y, target_min_x};
		item_c.hi   = {target_max_z, target_max_y, target_max_x};
		item_c.mv   = {move_z, move_y, move_x};
		for (int k = 0; k < NUM_AXES; k++) begin
			num1 = 33'($signed(item_c.lo[k])) - $signed({2'b00, item_c.size[k]});
			neg1 = num1[32];
			mag1 = neg1 ? 32'(-num1) : num1[31:0];
			mag2 = item_c.hi[k][31] ? 32'(-item_c.hi[k]) : item_c.hi[k];
			item_c.qneg1[k]    = neg1 ^ item_c.mv[k][31];
			item_c.qneg2[k]    = item_c.hi[k][31] ^ item_c.mv[k][31];
			item_c.still_ok[k] = ($signed({1'b0, item_c.size[k]}) > $signed(item_c.lo[k]))
				&& ($signed(item_c.hi[k]) > 32'sd0);
			dvd1_c[k] = {mag1, {FRAC_BITS{1'b0}}};
			dvd2_c[k] = {mag2, {FRAC_BITS{1'b0}}};
			dvs_c[k]  = item_c.mv[k][31] ? 32'(-item_c.mv[k]) : item_c.mv[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_c;
		for (int k = 0; k < NUM_AXES; k++) begin
			dvd1_s1[k] <= dvd1_c[k];
			dvd2_s1[k] <= dvd2_c[k];
			dvs_s1[k]  <= dvs_c[k];
		end
	end

	genvar g;
	for (g = 0; g < NUM_AXES; g++) begin : g_axis
		scai_div #(.NB(N), .DB(32)) u_div_lo (
			.clk      (clk),
			.dividend (dvd1_s1[g]),
			.divisor  (dvs_s1[g]),
			.quotient (qm1[g])
		);
		scai_div #(.NB(N), .DB(32)) u_div_hi (
			.clk      (clk),
			.dividend (dvd2_s1[g]),
			.divisor  (dvs_s1[g]),
			.quotient (qm2[g])
		);
	end

	scai_delay #(.W($bits(item_t)), .DEPTH(N)) u_item_dly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_data   (item_s1),
		.out_valid (valid_d),
		.out_data  (item_d)
	);

	// signed quotients, ordered, and the per-axis pass test
	always_comb begin
		logic signed [QW-1:0] q1;
		logic signed [QW-1:0] q2;
		for (int k = 0; k < NUM_AXES; k++) begin
			q1 = item_d.qneg1[k] ? QW'(-{1'b0, qm1[k]}) : {1'b0, qm1[k]};
			q2 = item_d.qneg2[k] ? QW'(-{1'b0, qm2[k]}) : {1'b0, qm2[k]};
			tlo_c[k] = (q1 > q2) ? q2 : q1;
			thi_c[k] = (q1 > q2) ? q1 : q2;
			if (item_d.mv[k] != '0)
				pass_c[k] = tlo_c[k] < thi_c[k];
			else
				pass_c[k] = item_d.still_ok[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		item_s2 <= item_d;
		pass_s2 <= pass_c;
		for (int k = 0; k < NUM_AXES; k++) begin
			tlo_s2[k] <= tlo_c[k];
			thi_s2[k] <= thi_c[k];
		end
	end

	// latest entry, earliest exit; earlier axis keeps a tie
	always_comb begin
		logic signed [QW-1:0] te;
		logic signed [QW-1:0] tx;
		logic                 have;
		logic                 ok;
		axis_t                ea;
		axis_t                xa;
		logic                 mvg;
		te   = '0;
		tx   = '0;
		have = 1'b0;
		ea   = AXIS_NONE;
		xa   = AXIS_NONE;
		for (int k = 0; k < NUM_AXES; k++) begin
			mvg = item_s2.mv[k] != '0;
			if (mvg && (!have || tlo_s2[k] > te)) begin
				te = tlo_s2[k];
				ea = axis_t'(k);
			end
			if (mvg && (!have || thi_s2[k] < tx)) begin
				tx = thi_s2[k];
				xa = axis_t'(k);
			end
			have = have || mvg;
		end
		ok = (&pass_s2) && !(have && te >= tx);

		res_c = '0;
		res_c.still      = !have;
		res_c.enter_axis = AXIS_NONE;
		res_c.exit_axis  = AXIS_NONE;
		if (ok && !have) begin
			res_c.hit     = 1'b1;
			res_c.t_enter = 32'h8000_0000;
			res_c.t_exit  = 32'h7fff_ffff;
		end else if (ok) begin
			res_c.hit = 1'b1;
			if (te[QW-1:31] == '0 || te[QW-1:31] == '1)
				res_c.t_enter = te[31:0];
			else
				res_c.t_enter = te[QW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
			if (tx[QW-1:31] == '0 || tx[QW-1:31] == '1)
				res_c.t_exit = tx[31:0];
			else
				res_c.t_exit = tx[QW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
			res_c.enter_axis = ea;
			res_c.exit_axis  = xa;
			res_c.enter_neg  = item_s2.mv[ea][31];
			res_c.exit_neg   = !item_s2.mv[xa][31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s3 <= item_s2;
		res_s3  <= res_c;
	end

	scai_area #(.FRAC_BITS(FRAC_BITS)) u_area_enter (
		.clk  (clk),
		.item (item_s3),
		.t    ($signed(res_s3.t_enter)),
		.skip (res_s3.enter_axis),
		.area (area_e)
	);

	scai_area #(.FRAC_BITS(FRAC_BITS)) u_area_exit (
		.clk  (clk),
		.item (item_s3),
		.t    ($signed(res_s3.t_exit)),
		.skip (res_s3.exit_axis),
		.area (area_x)
	);

	scai_delay #(.W($bits(res_t)), .DEPTH(AREA_LAT)) u_res_dly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_data   (res_s3),
		.out_valid (valid_a),
		.out_data  (res_a)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_a;
		end
	end

	// areas only mean something for a moving hit
	always_ff @(posedge clk) begin
		res_q        <= res_a;
		area_enter_q <= (res_a.hit && !res_a.still) ? area_e : 64'sd0;
		area_exit_q  <= (res_a.hit && !res_a.still) ? area_x : 64'sd0;
	end

	assign done                  = done_q;
	assign hit                   = res_q.hit;
	assign stationary            = res_q.still;
	assign t_enter               = res_q.t_enter;
	assign t_exit                = res_q.t_exit;
	assign enter_axis            = res_q.enter_axis;
	assign enter_moving_negative = res_q.enter_neg;
	assign exit_axis             = res_q.exit_axis;
	assign exit_moving_negative  = res_q.exit_neg;
	assign area_enter            = area_enter_q;
	assign area_exit             = area_exit_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("word did not come out after the pipeline latency");

	a_still_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit && stationary |-> enter_axis == AXIS_NONE && exit_axis == AXIS_NONE
			&& area_enter == 64'sd0 && area_exit == 64'sd0)
		else $error("stationary hit carries an axis or area");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> t_enter == 32'sd0 && t_exit == 32'sd0
			&& enter_axis == AXIS_NONE && exit_axis == AXIS_NONE && area_enter == 64'sd0)
		else $error("miss word is not cleared");

	a_moving_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit && !stationary |-> enter_axis != AXIS_NONE && exit_axis != AXIS_NONE
			&& t_enter <= t_exit)
		else $error("moving hit has no axis or an inverted interval");

endmodule

// ===== sim/tb_swept_box_collision_interval_unit.sv =====
// testbench for the swept box collision interval unit: directed and random box pairs
// depends on scai_pkg and swept_box_collision_interval_unit; self-checking, no files
`timescale 1ns / 1ps

module tb_swept_box_collision_interval_unit;
	import scai_pkg::*;

	localparam int FRAC = 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = FRAC + 60;

	typedef struct {
		bit [30:0] size [3];
		bit signed [31:0] lo [3];
		bit signed [31:0] hi [3];
		bit signed [31:0] mv [3];
	} pair_t;

	typedef struct {
		bit hit;
		bit still;
		bit signed [31:0] te;
		bit signed [31:0] tx;
		axis_t ea;
		bit eneg;
		axis_t xa;
		bit xneg;
		bit signed [63:0] ae;
		bit signed [63:0] ax;
	} outcome_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [30:0] mover_size_x = 0, mover_size_y = 0, mover_size_z = 0;
	logic signed [31:0] target_min_x = 0, target_max_x = 0;
	logic signed [31:0] target_min_y = 0, target_max_y = 0;
	logic signed [31:0] target_min_z = 0, target_max_z = 0;
	logic signed [31:0] move_x = 0, move_y = 0, move_z = 0;
	logic done, hit, stationary, enter_moving_negative, exit_moving_negative;
	logic signed [31:0] t_enter, t_exit;
	logic [1:0] enter_axis, exit_axis;
	logic signed [63:0] area_enter, area_exit;

	outcome_t pending_q[$];
	int errors = 0;
	int words_sent = 0;
	int hits_seen = 0;
	int stills_seen = 0;
	int idle_cycles = 0;
	bit quiet = 0;

	swept_box_collision_interval_unit #(.FRAC_BITS(FRAC)) u_top (.*);

	always #5 clk = ~clk;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint overlap_area(pair_t p, int skip, longint t);
		longint prod, d, a, b;
		prod = 1;
		for (int k = 0; k < 3; k++) begin
			if (k == skip) continue;
			d = (longint'(p.mv[k]) * t) / (64'sd1 <<< FRAC);
			a = (d > longint'(p.lo[k])) ? d : longint'(p.lo[k]);
			b = longint'(p.size[k]) + d;
			if (b > longint'(p.hi[k])) b = p.hi[k];
			prod = prod * clamp32(b - a);
		end
		return prod;
	endfunction

	function automatic outcome_t sweep_interval(pair_t p);
		outcome_t r;
		longint t1 [3], t2 [3];
		longint q1, q2, s, te, tx, se, sx;
		bit ok, still;
		int ea, xa;
		ok = 1;
		still = 1;
		for (int k = 0; k < 3; k++) begin
			if (p.mv[k] != 0) begin
				still = 0;
				q1 = ((longint'(p.lo[k]) - longint'(p.size[k])) * (64'sd1 <<< FRAC))
					/ longint'(p.mv[k]);
				q2 = (longint'(p.hi[k]) * (64'sd1 <<< FRAC)) / longint'(p.mv[k]);
				if (q1 > q2) begin
					s = q1; q1 = q2; q2 = s;
				end
				if (!(q1 < q2)) ok = 0;
				t1[k] = q1;
				t2[k] = q2;
			end else begin
				t1[k] = 64'h8000_0000_0000_0000;
				t2[k] = 64'h7FFF_FFFF_FFFF_FFFF;
				if (!(longint'(p.size[k]) > longint'(p.lo[k]) && p.hi[k] > 0)) ok = 0;
			end
		end
		te = 64'h8000_0000_0000_0000;
		tx = 64'h7FFF_FFFF_FFFF_FFFF;
		ea = AXIS_NONE;
		xa = AXIS_NONE;
		for (int k = 0; k < 3; k++) begin
			if (te < t1[k]) begin
				te = t1[k]; ea = k;
			end
			if (tx > t2[k]) begin
				tx = t2[k]; xa = k;
			end
		end
		if (te >= tx) ok = 0;
		r = '{default: 0};
		r.still = still;
		r.ea = AXIS_NONE;
		r.xa = AXIS_NONE;
		if (ok && still) begin
			r.hit = 1;
			r.te = 32'h8000_0000;
			r.tx = 32'h7FFF_FFFF;
		end else if (ok) begin
			se = clamp32(te);
			sx = clamp32(tx);
			r.hit = 1;
			r.te = se[31:0];
			r.tx = sx[31:0];
			r.ea = axis_t'(ea);
			r.xa = axis_t'(xa);
			r.eneg = (ea < 3) && (p.mv[ea] < 0);
			r.xneg = (xa < 3) && (p.mv[xa] >= 0);
			r.ae = overlap_area(p, ea, se);
			r.ax = overlap_area(p, xa, sx);
		end
		return r;
	endfunction

	// hold start low for a random gap, except in the quiet stretch
	task automatic send_pair(pair_t p);
		while (!quiet && $urandom_range(99) < 13) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		mover_size_x <= p.size[0]; mover_size_y <= p.size[1]; mover_size_z <= p.size[2];
		target_min_x <= p.lo[0]; target_max_x <= p.hi[0];
		target_min_y <= p.lo[1]; target_max_y <= p.hi[1];
		target_min_z <= p.lo[2]; target_max_z <= p.hi[2];
		move_x <= p.mv[0]; move_y <= p.mv[1]; move_z <= p.mv[2];
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_q.push_back(sweep_interval(p));
		words_sent++;
		@(negedge clk);
	endtask

	function automatic bit [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(32'h0006_0000) - 32'h0003_0000;
		endcase
	endfunction

	// mostly boxes near each other with moderate motion, some wild values
	function automatic pair_t rand_pair();
		pair_t p;
		bit signed [31:0] a, b;
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(9) < 7) begin
				p.size[k] = 31'($urandom_range(32'h0004_0000));
				a = $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
				b = a + $signed($urandom_range(32'h0004_0000));
				p.lo[k] = a;
				p.hi[k] = b;
				p.mv[k] = ($urandom_range(4) == 0) ? 0 :
					$signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
			end else begin
				p.size[k] = 31'($urandom);
				p.lo[k] = rand_word();
				p.hi[k] = rand_word();
				p.mv[k] = ($urandom_range(3) == 0) ? 0 : rand_word();
			end
		end
		return p;
	endfunction

	function automatic pair_t make_pair(int sz, int lo, int hi, int mx, int my, int mz);
		pair_t p;
		for (int k = 0; k < 3; k++) begin
			p.size[k] = 31'(sz);
			p.lo[k] = lo;
			p.hi[k] = hi;
		end
		p.mv[0] = mx; p.mv[1] = my; p.mv[2] = mz;
		return p;
	endfunction

	task automatic test_stationary();
		send_pair(make_pair(32'h10000, 32'h8000, 32'h20000, 0, 0, 0));
		send_pair(make_pair(32'h10000, 32'h30000, 32'h40000, 0, 0, 0));
		send_pair(make_pair(32'h10000, 32'h10000, 32'h20000, 0, 0, 0));
	endtask

	task automatic test_motion();
		send_pair(make_pair(32'h10000, 32'h20000, 32'h30000, 32'h40000, 0, 0));
		send_pair(make_pair(32'h10000, -32'sh30000, -32'sh20000, -32'sh40000, 0, 0));
		// equal entry times on every axis, x must win
		send_pair(make_pair(32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h10000, 32'h10000));
		send_pair(make_pair(32'h10000, 32'h20000, 32'h30000, 32'h10000, -32'sh10000, 0));
		// empty target range on a moving axis
		send_pair(make_pair(32'h10000, 32'h20000, 32'h20000 - 32'h10000, 32'h10000, 0, 0));
		// tiny motion saturates the times
		send_pair(make_pair(32'h10000, 32'h20000, 32'h30000, 1, 0, 0));
		send_pair(make_pair(32'h10000, -32'sh20000, 32'h20000, 1, 1, -1));
	endtask

	task automatic test_extremes();
		send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_pair(make_pair(0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
		send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, -1, -1, -1));
		send_pair(make_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF));
		send_pair(make_pair(32'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001));
		send_pair(make_pair(0, 0, 0, 0, 0, 1));
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			quiet = (i >= count / 3) && (i < count / 3 + 150);
			send_pair(rand_pair());
		end
		quiet = 0;
	endtask

	always @(posedge clk) begin
		outcome_t e;
		if (start && !busy || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (done) begin
			if (pending_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, hit); errors++;
				end
				if (stationary !== e.still) begin
					$error("stationary: expected %0d, got %0d", e.still, stationary); errors++;
				end
				if (t_enter !== e.te) begin
					$error("t_enter: expected %0d, got %0d", e.te, t_enter); errors++;
				end
				if (t_exit !== e.tx) begin
					$error("t_exit: expected %0d, got %0d", e.tx, t_exit); errors++;
				end
				if (enter_axis !== e.ea) begin
					$error("enter_axis: expected %0d, got %0d", e.ea, enter_axis); errors++;
				end
				if (enter_moving_negative !== e.eneg) begin
					$error("enter_moving_negative: expected %0d, got %0d",
						e.eneg, enter_moving_negative); errors++;
				end
				if (exit_axis !== e.xa) begin
					$error("exit_axis: expected %0d, got %0d", e.xa, exit_axis); errors++;
				end
				if (exit_moving_negative !== e.xneg) begin
					$error("exit_moving_negative: expected %0d, got %0d",
						e.xneg, exit_moving_negative); errors++;
				end
				if (area_enter !== e.ae) begin
					$error("area_enter: expected %0d, got %0d", e.ae, area_enter); errors++;
				end
				if (area_exit !== e.ax) begin
					$error("area_exit: expected %0d, got %0d", e.ax, area_exit); errors++;
				end
				if (e.hit) hits_seen++;
				if (e.still) stills_seen++;
			end
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d words outstanding", pending_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		test_stationary();
		test_motion();
		test_extremes();
		test_random(640);
		start <= 0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("sent %0d box pairs: %0d hits, %0d stationary", words_sent, hits_seen,
			stills_seen);
		if (errors == 0 && pending_q.size() == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/scai_pkg.sv
hw/rtl/scai_div.sv
hw/rtl/scai_delay.sv
hw/rtl/scai_area.sv
hw/rtl/swept_box_collision_interval_unit.sv
sim/tb_swept_box_collision_interval_unit.sv
